FILE: design/horizontal_fir_resampler_unit_assert.svh
// Assertion macros shared by the resampler checker.
// Needs nothing else; include by bare file name.
`ifndef HORIZONTAL_FIR_RESAMPLER_UNIT_ASSERT_SVH
`define HORIZONTAL_FIR_RESAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define HFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define HFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/hfr_pkg.sv
// Shared types and constants for the horizontal FIR resampler.
// No dependencies; used by every module of the block but hfr_ram.
package hfr_pkg;

  // Default sizes
  localparam int MAX_SOURCE_WIDTH_DEF = 2048;
  localparam int MAX_OUTPUT_WIDTH_DEF = 1024;
  localparam int MAX_TAPS_DEF         = 16;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 10;
  localparam int TAPIDX_W  = 4;
  localparam int START_W   = 11;
  localparam int COEF_W    = 18;
  localparam int SRCPOS_W  = 11;
  localparam int PIXEL_W   = 8;
  localparam int TAPCNT_W  = 5;
  localparam int PROD_W    = PIXEL_W + 1 + COEF_W;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = 5'd4;
  localparam int Q16_HALF = 32768;

  // Register index
  localparam logic REG_TAP_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_COEF    = 2'd1,
    CMD_PIXEL   = 2'd2,
    CMD_COMPUTE = 2'd3
  } hfr_op_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // compute request taken: latch index, clear acc
    logic issue;     // read one tap
    logic load_out;  // move result into output register
  } hfr_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic taps_zero;
    logic last_tap;
    logic out_busy;
  } hfr_sts_t;

endpackage

FILE: design/hfr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/hfr_ctrl.sv
// Sequencer for the resampler: accepts requests, steps the tap loop.
// Depends on hfr_pkg.
module hfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  hfr_pkg::hfr_op_t  op,
  input  hfr_pkg::hfr_sts_t sts,
  output hfr_pkg::hfr_ctl_t ctl,
  output logic              idle
);
  import hfr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TAPS   = 5'b00010,
    S_DRAIN1 = 5'b00100,
    S_DRAIN2 = 5'b01000,
    S_DONE   = 5'b10000
  } hfr_state_t;

  hfr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && op == CMD_COMPUTE) begin
          ctl.start = 1'b1;
          state_nxt = sts.taps_zero ? S_DRAIN1 : S_TAPS;
        end
      end
      S_TAPS: begin
        ctl.issue = 1'b1;
        if (sts.last_tap) begin
          state_nxt = S_DRAIN1;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_DONE;
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

endmodule

FILE: design/hfr_dpath.sv
// Resampler datapath: table RAMs, tap addressing, MAC, round/clamp, output reg.
// Depends on hfr_pkg and hfr_ram.
module hfr_dpath #(
  parameter int MAX_SOURCE_WIDTH = hfr_pkg::MAX_SOURCE_WIDTH_DEF,
  parameter int MAX_OUTPUT_WIDTH = hfr_pkg::MAX_OUTPUT_WIDTH_DEF,
  parameter int MAX_TAPS         = hfr_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  hfr_pkg::hfr_op_t              op,
  input  logic [hfr_pkg::INDEX_W-1:0]   out_index,
  input  logic [hfr_pkg::TAPIDX_W-1:0]  tap_index,
  input  logic [hfr_pkg::START_W-1:0]   start_position,
  input  logic [hfr_pkg::COEF_W-1:0]    coefficient,
  input  logic [hfr_pkg::SRCPOS_W-1:0]  src_position,
  input  logic [hfr_pkg::PIXEL_W-1:0]   pixel,
  input  logic [hfr_pkg::TAPCNT_W-1:0]  tap_count,
  input  hfr_pkg::hfr_ctl_t             ctl,
  output hfr_pkg::hfr_sts_t             sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [hfr_pkg::PIXEL_W-1:0]   out_pixel,
  output logic [hfr_pkg::INDEX_W-1:0]   result_index
);
  import hfr_pkg::*;

  localparam int SRC_AW = $clog2(MAX_SOURCE_WIDTH);
  localparam int OUT_AW = $clog2(MAX_OUTPUT_WIDTH);
  localparam int WT_AW  = $clog2(MAX_OUTPUT_WIDTH * MAX_TAPS);
  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int POS_W  = START_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

  // Table writes
  logic we_start, we_wt, we_line;

  assign we_start = in_fire && op == CMD_START && 32'(out_index) < MAX_OUTPUT_WIDTH;
  assign we_wt    = in_fire && op == CMD_COEF && 32'(out_index) < MAX_OUTPUT_WIDTH
                    && 32'(tap_index) < MAX_TAPS;
  assign we_line  = in_fire && op == CMD_PIXEL && 32'(src_position) < MAX_SOURCE_WIDTH;

  // Compute state
  logic [INDEX_W-1:0]      x_r;
  logic                    xoob_r;
  logic [TAP_W-1:0]        tap_r;
  logic [TAP_W-1:0]        taps_sat;
  logic [POS_W-1:0]        pos;
  logic                    rd_vld_r, poob_r, mul_vld_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W:0]    rnd;
  logic [PIXEL_W-1:0]      pix_q;
  logic [PIXEL_W-1:0]      px;
  logic                    out_vld_r;
  logic [PIXEL_W-1:0]      out_pixel_r;
  logic [INDEX_W-1:0]      result_index_r;

  logic [START_W-1:0] start_rdata;
  logic [PIXEL_W-1:0] line_rdata;
  logic [COEF_W-1:0]  wt_rdata;

  assign taps_sat = (32'(tap_count) > MAX_TAPS) ? TAP_W'(MAX_TAPS) : TAP_W'(tap_count);
  assign pos      = POS_W'(start_rdata) + POS_W'(tap_r);

  hfr_ram #(.WIDTH(START_W), .DEPTH(MAX_OUTPUT_WIDTH)) u_start_ram (
    .clk   (clk),
    .we    (we_start),
    .waddr (OUT_AW'(out_index)),
    .wdata (start_position),
    .re    (ctl.start),
    .raddr (OUT_AW'(out_index)),
    .rdata (start_rdata)
  );

  hfr_ram #(.WIDTH(COEF_W), .DEPTH(MAX_OUTPUT_WIDTH * MAX_TAPS)) u_wt_ram (
    .clk   (clk),
    .we    (we_wt),
    .waddr (WT_AW'(32'(out_index) * MAX_TAPS + 32'(tap_index))),
    .wdata (coefficient),
    .re    (ctl.issue),
    .raddr (WT_AW'(32'(x_r) * MAX_TAPS + 32'(tap_r))),
    .rdata (wt_rdata)
  );

  hfr_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_SOURCE_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (we_line),
    .waddr (SRC_AW'(src_position)),
    .wdata (pixel),
    .re    (ctl.issue),
    .raddr (SRC_AW'(pos)),
    .rdata (line_rdata)
  );

  // Pixels past the line store read as zero
  assign px       = poob_r ? '0 : line_rdata;
  assign prod_nxt = $signed({1'b0, px}) * $signed(wt_rdata);

  // Round half up, floor shift, clamp to 0..255
  always_comb begin
    rnd = (ACC_W+1)'(acc_r) + (ACC_W+1)'(Q16_HALF);
    if (xoob_r || rnd[ACC_W]) begin
      pix_q = '0;
    end else if (|rnd[ACC_W-1:16+PIXEL_W]) begin
      pix_q = '1;
    end else begin
      pix_q = rnd[16+PIXEL_W-1:16];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r    <= out_index;
      xoob_r <= 32'(out_index) >= MAX_OUTPUT_WIDTH;
    end
    if (ctl.start) begin
      tap_r <= '0;
    end else if (ctl.issue) begin
      tap_r <= tap_r + TAP_W'(1);
    end
    poob_r <= 32'(pos) >= MAX_SOURCE_WIDTH;
    prod_r <= prod_nxt;
    if (ctl.start) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.load_out) begin
      out_pixel_r    <= pix_q;
      result_index_r <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= ctl.issue;
      mul_vld_r <= rd_vld_r;
      if (ctl.load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts.taps_zero = (taps_sat == '0);
  assign sts.last_tap  = ((tap_r + TAP_W'(1)) == taps_sat);
  assign sts.out_busy  = out_vld_r && !out_ready;

  assign out_valid    = out_vld_r;
  assign out_pixel    = out_pixel_r;
  assign result_index = result_index_r;

endmodule

FILE: design/horizontal_fir_resampler_unit.sv
// Horizontal FIR resampler for one image row. Requests on the input stream
// either load a table (start position per output pixel, signed Q16 tap weight
// per output pixel and tap, source pixel into the line store) or compute one
// output pixel: the sum over tap_count taps of pixel[start+t]*weight[x][t],
// rounded by +32768, shifted right 16 and clamped to 0..255. A table load does
// not take the block out of idle. A compute request occupies the block while
// the single multiply-accumulate walks the saturated tap count one tap per
// cycle behind the registered reads of the line and weight RAMs, then passes
// its drain and done states. A finished pixel waits in the output register,
// so the next request is taken while it is still unclaimed; a following
// compute then holds in its done state until that pixel is taken.
// Tables power up undefined; read only what was loaded. tap_count lives at APB
// byte address 0 and saturates at MAX_TAPS.
//
// Depends on hfr_pkg, hfr_ctrl, hfr_dpath and hfr_ram.
module horizontal_fir_resampler_unit #(
  parameter int MAX_SOURCE_WIDTH = hfr_pkg::MAX_SOURCE_WIDTH_DEF,
  parameter int MAX_OUTPUT_WIDTH = hfr_pkg::MAX_OUTPUT_WIDTH_DEF,
  parameter int MAX_TAPS         = hfr_pkg::MAX_TAPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] out_index, [13:10] tap_index, [24:14] start_position,
  // [42:25] coefficient, [53:43] src_position, [61:54] pixel, [63:62] zero
  input  logic [63:0] in_tdata,
  // [1:0] command
  input  logic [1:0]  in_tuser,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_pixel, [17:8] result_index, [23:18] zero
  output logic [23:0] out_tdata,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hfr_pkg::*;

  // Unpacked request fields
  logic [INDEX_W-1:0]  f_out_index;
  logic [TAPIDX_W-1:0] f_tap_index;
  logic [START_W-1:0]  f_start;
  logic [COEF_W-1:0]   f_coef;
  logic [SRCPOS_W-1:0] f_src_pos;
  logic [PIXEL_W-1:0]  f_pixel;
  hfr_op_t             op;

  assign f_out_index = in_tdata[9:0];
  assign f_tap_index = in_tdata[13:10];
  assign f_start     = in_tdata[24:14];
  assign f_coef      = in_tdata[42:25];
  assign f_src_pos   = in_tdata[53:43];
  assign f_pixel     = in_tdata[61:54];
  assign op          = hfr_op_t'(in_tuser);

  // Handshake: requests are taken only while the sequencer is idle
  logic in_fire;
  logic idle;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  // Config register: word index is paddr[2], one register at word 0
  logic [TAPCNT_W-1:0] tap_count_r;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TAP_COUNT) begin
      tap_count_r <= cfg_pwdata[TAPCNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_TAP_COUNT) begin
      cfg_prdata = 32'(tap_count_r);
    end
  end

  // Controller and datapath
  hfr_ctl_t ctl;
  hfr_sts_t sts;
  logic [PIXEL_W-1:0] res_pixel;
  logic [INDEX_W-1:0] res_index;

  hfr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .op      (op),
    .sts     (sts),
    .ctl     (ctl),
    .idle    (idle)
  );

  hfr_dpath #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_OUTPUT_WIDTH (MAX_OUTPUT_WIDTH),
    .MAX_TAPS         (MAX_TAPS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .op             (op),
    .out_index      (f_out_index),
    .tap_index      (f_tap_index),
    .start_position (f_start),
    .coefficient    (f_coef),
    .src_position   (f_src_pos),
    .pixel          (f_pixel),
    .tap_count      (tap_count_r),
    .ctl            (ctl),
    .sts            (sts),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_pixel      (res_pixel),
    .result_index   (res_index)
  );

  assign out_tdata = {6'b0, res_index, res_pixel};

endmodule

FILE: design/hfr_checker.sv
// Port-level checks for the resampler, bound to the top level.
// Depends on hfr_pkg and horizontal_fir_resampler_unit_assert.svh.
`include "horizontal_fir_resampler_unit_assert.svh"

module hfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  import hfr_pkg::*;

  // A waiting result keeps its value
  `HFR_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // A compute request makes the block busy in the next cycle
  `HFR_ASSERT_NXT(a_busy_after_compute, clk, rst_n, in_tvalid && in_tready && in_tuser == CMD_COMPUTE, !in_tready, "still ready after compute request")

  // Only a compute request can take the block out of ready
  `HFR_ASSERT_NXT(a_ready_stays, clk, rst_n, in_tready && !(in_tvalid && in_tuser == CMD_COMPUTE), in_tready, "ready dropped without compute request")

  // Padding bits of a result stay clear
  `HFR_ASSERT_NOW(a_out_pad, clk, rst_n, out_tvalid, out_tdata[23:18] == 6'b0, "result padding not zero")

endmodule

bind horizontal_fir_resampler_unit hfr_checker u_hfr_checker (.*);
